// ----- hdl/heading_turn_pd_controller_top_macros.svh -----
// assertion macros for the heading turn pd controller checker
`ifndef HEADING_TURN_PD_CONTROLLER_TOP_MACROS_SVH
`define HEADING_TURN_PD_CONTROLLER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htpd check failed");

// antecedent implies consequent in the next cycle
`define HTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htpd check failed");

`endif

// ----- hdl/htpd_pkg.sv -----
// shared types and constants of the heading turn pd controller
`default_nettype none

package htpd_pkg;

    localparam int RATE_FRAC_BITS = 12;
    localparam int RATE_SHIFT     = 36 - RATE_FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = PROD_W - RATE_SHIFT;
    localparam int FOLD_SHIFT = 24;

    localparam logic signed [MUL_B_W-1:0] FOLD_RECIP = 20'sd46603;
    localparam logic signed [MUL_B_W-1:0] DEG2RAD    = 20'sd292816;
    localparam logic [PROD_W-1:0] RND_HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (RATE_SHIFT - 1);

    localparam logic [15:0] FULL_TURN_16 = 16'd360;
    localparam logic [9:0]  FULL_TURN_10 = 10'd360;
    localparam logic signed [9:0] GOAL_MAX = 10'sd359;
    localparam logic signed [9:0] GOAL_MIN = -10'sd359;

    localparam logic [1:0] KIND_HEADING = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_BREAK   = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    localparam logic [1:0] STAT_TURNING = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_BROKEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOL   = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_FOLD_MUL,
        OP_FOLD_SUB,
        OP_FOLD_FIX,
        OP_BREAK_SET,
        OP_START,
        OP_ARM,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_D,
        OP_SUM,
        OP_ABS,
        OP_MUL_R,
        OP_ROUND,
        OP_CLAMP,
        OP_BREAK_STOP,
        OP_FINISH
    } t_dp_op;

    typedef enum logic [1:0] {
        RES_RATE,
        RES_DONE,
        RES_BREAK
    } t_res_sel;

    typedef struct packed {
        t_dp_op   op;
        logic     capture;
        logic     load_out;
        t_res_sel res;
    } t_dp_cmd;

    typedef struct packed {
        logic turning;
        logic break_pending;
        logic within_tol;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/htpd_in_if.sv -----
// input word channel of the heading turn pd controller
`default_nettype none

interface htpd_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [15:0] heading_degree;
    logic signed [9:0]  goal_degree;
    logic              break_request;

    modport source (
        output valid, kind, heading_degree, goal_degree, break_request,
        input  ready
    );
    modport sink (
        input  valid, kind, heading_degree, goal_degree, break_request,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/htpd_out_if.sv -----
// result word channel of the heading turn pd controller
`default_nettype none

interface htpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] turn_rate;
    logic [1:0]         status;
    logic signed [11:0] heading_error;
    logic               last;

    modport source (
        output valid, turn_rate, status, heading_error, last,
        input  ready
    );
    modport sink (
        input  valid, turn_rate, status, heading_error, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/htpd_ctrl.sv -----
// sequencing state machine of the heading turn pd controller
`default_nettype none

module htpd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    htpd_in_if.sink             i_in_word,
    input  htpd_pkg::t_dp_status i_status,
    output htpd_pkg::t_dp_cmd   o_cmd
);
    import htpd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FOLD_MUL,
        S_FOLD_SUB,
        S_FOLD_FIX,
        S_BREAK,
        S_START,
        S_START_CHK,
        S_TICK,
        S_MUL_P,
        S_MUL_D,
        S_SUM,
        S_ABS,
        S_MUL_R,
        S_ROUND,
        S_CLAMP,
        S_SEND_RATE,
        S_SEND_DONE,
        S_SEND_START,
        S_SEND_BRK
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    logic    accept;
    t_dp_cmd cmd;

    assign accept          = i_in_word.valid && r_in_ready;
    assign i_in_word.ready = r_in_ready;
    assign o_cmd           = cmd;

    always_comb begin
        n_state      = r_state;
        cmd.op       = OP_NONE;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.res      = RES_RATE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (i_in_word.kind)
                        KIND_HEADING: n_state = S_FOLD_MUL;
                        KIND_START:   n_state = S_START;
                        KIND_BREAK:   n_state = S_BREAK;
                        KIND_TICK:    n_state = S_TICK;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_FOLD_MUL: begin
                cmd.op  = OP_FOLD_MUL;
                n_state = S_FOLD_SUB;
            end
            S_FOLD_SUB: begin
                cmd.op  = OP_FOLD_SUB;
                n_state = S_FOLD_FIX;
            end
            S_FOLD_FIX: begin
                cmd.op  = OP_FOLD_FIX;
                n_state = S_IDLE;
            end
            S_BREAK: begin
                cmd.op  = OP_BREAK_SET;
                n_state = S_IDLE;
            end
            S_START: begin
                if (i_status.turning) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.op  = OP_START;
                    n_state = S_START_CHK;
                end
            end
            S_START_CHK: begin
                if (i_status.within_tol) begin
                    n_state = S_SEND_START;
                end else begin
                    cmd.op  = OP_ARM;
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (!i_status.turning) begin
                    n_state = S_IDLE;
                end else if (i_status.break_pending) begin
                    n_state = S_SEND_BRK;
                end else begin
                    cmd.op  = OP_ERR;
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P: begin
                cmd.op  = OP_MUL_P;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.op  = OP_MUL_D;
                n_state = S_SUM;
            end
            S_SUM: begin
                cmd.op  = OP_SUM;
                n_state = S_ABS;
            end
            S_ABS: begin
                cmd.op  = OP_ABS;
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                cmd.op  = OP_MUL_R;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                cmd.op  = OP_ROUND;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.op  = OP_CLAMP;
                n_state = S_SEND_RATE;
            end
            S_SEND_RATE: begin
                if (i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.res      = RES_RATE;
                    n_state      = i_status.within_tol ? S_SEND_DONE : S_IDLE;
                end
            end
            S_SEND_DONE: begin
                if (i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.res      = RES_DONE;
                    cmd.op       = OP_FINISH;
                    n_state      = S_IDLE;
                end
            end
            S_SEND_START: begin
                if (i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.res      = RES_DONE;
                    n_state      = S_IDLE;
                end
            end
            S_SEND_BRK: begin
                if (i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.res      = RES_BREAK;
                    cmd.op       = OP_BREAK_STOP;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/htpd_dp.sv -----
// datapath of the heading turn pd controller: state, shared multiplier, clamp, result register
`default_nettype none

module htpd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  htpd_pkg::t_dp_cmd                   i_cmd,
    output htpd_pkg::t_dp_status                o_status,
    input  logic signed [15:0]                  i_heading_degree,
    input  logic signed [9:0]                   i_goal_degree,
    input  logic                                i_break_request,
    input  logic                                i_cfg_we,
    input  logic [htpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [htpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    htpd_out_if.source                          o_out_word
);
    import htpd_pkg::*;

    // configuration
    logic [15:0] r_prop_gain;
    logic [15:0] r_deriv_gain;
    logic [14:0] r_min_rate;
    logic [14:0] r_max_rate;
    logic [8:0]  r_stop_tol;

    // controller state
    logic signed [9:0]  r_heading_fold;
    logic               r_turning;
    logic [8:0]         r_goal;
    logic signed [11:0] r_prev_err;
    logic               r_break_pending;

    // captured word and working registers
    logic signed [15:0]        r_in_heading;
    logic signed [9:0]         r_in_goal;
    logic                      r_in_break;
    logic [15:0]               r_habs;
    logic [9:0]                r_rem;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MUL_A_W-1:0] r_acc;
    logic [MUL_A_W-2:0]        r_abs;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic signed [11:0]        r_err;
    logic signed [15:0]        r_rate;

    // result register
    logic               r_out_valid;
    logic signed [15:0] r_out_rate;
    logic [1:0]         r_out_status;
    logic signed [11:0] r_out_err;
    logic               r_out_last;

    logic [15:0]               habs;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [6:0]                fold_q;
    logic [15:0]               fold_qm;
    logic [15:0]               fold_diff;
    logic [9:0]                rem_fix;
    logic [9:0]                rem_neg;
    logic signed [9:0]         goal_sat;
    logic signed [9:0]         goal_wrap;
    logic signed [11:0]        fold_ext;
    logic signed [11:0]        err_start;
    logic signed [11:0]        err_tick;
    logic [11:0]               err_abs;
    logic                      tol_hit;
    logic signed [MUL_B_W-1:0] err_diff;
    logic signed [MUL_A_W-1:0] acc_neg;
    logic [PROD_W-1:0]         rnd_sum;
    logic                      err_neg;
    logic                      over;
    logic [14:0]               ar1;
    logic                      neg1;
    logic                      under;
    logic [14:0]               ar2;
    logic                      neg2;
    logic signed [15:0]        rate_mag;
    logic                      out_free;

    assign habs = r_in_heading[15] ? 16'(-r_in_heading) : 16'(r_in_heading);

    assign fold_q    = r_prod[FOLD_SHIFT+6:FOLD_SHIFT];
    assign fold_qm   = {9'd0, fold_q} * FULL_TURN_16;
    assign fold_diff = r_habs - fold_qm;
    assign rem_fix   = (r_rem >= FULL_TURN_10) ? (r_rem - FULL_TURN_10) : r_rem;
    assign rem_neg   = -rem_fix;

    always_comb begin
        if (r_in_goal > GOAL_MAX) begin
            goal_sat = GOAL_MAX;
        end else if (r_in_goal < GOAL_MIN) begin
            goal_sat = GOAL_MIN;
        end else begin
            goal_sat = r_in_goal;
        end
    end

    assign goal_wrap = goal_sat + 10'sd360;
    assign fold_ext  = {{2{r_heading_fold[9]}}, r_heading_fold};
    assign err_start = {{2{goal_sat[9]}}, goal_sat} - fold_ext;
    assign err_tick  = $signed({3'b000, r_goal}) - fold_ext;
    assign err_abs   = r_err[11] ? 12'(-r_err) : 12'(r_err);
    assign tol_hit   = err_abs <= {3'b000, r_stop_tol};
    assign err_diff  = {{(MUL_B_W-12){r_prev_err[11]}}, r_prev_err}
                     - {{(MUL_B_W-12){r_err[11]}}, r_err};
    assign acc_neg   = -r_acc;
    assign rnd_sum   = {1'b0, r_prod[PROD_W-2:0]} + RND_HALF;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_FOLD_MUL: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, habs};
                mul_b = FOLD_RECIP;
            end
            OP_MUL_P: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, r_prop_gain};
                mul_b = {{(MUL_B_W-12){r_err[11]}}, r_err};
            end
            OP_MUL_D: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, r_deriv_gain};
                mul_b = err_diff;
            end
            OP_MUL_R: begin
                mul_a = {1'b0, r_abs};
                mul_b = DEG2RAD;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // magnitude clamp into the min/max band
    assign err_neg  = r_err[11];
    assign over     = r_mag > {{(MAG_W-15){1'b0}}, r_max_rate};
    assign ar1      = over ? r_max_rate : r_mag[14:0];
    assign neg1     = over ? err_neg : r_neg;
    assign under    = ar1 < r_min_rate;
    assign ar2      = under ? r_min_rate : ar1;
    assign neg2     = under ? err_neg : neg1;
    assign rate_mag = {1'b0, ar2};

    assign out_free = !r_out_valid || o_out_word.ready;

    assign o_status.turning       = r_turning;
    assign o_status.break_pending = r_break_pending;
    assign o_status.within_tol    = tol_hit;
    assign o_status.out_free      = out_free;

    assign o_out_word.valid         = r_out_valid;
    assign o_out_word.turn_rate     = r_out_rate;
    assign o_out_word.status        = r_out_status;
    assign o_out_word.heading_error = r_out_err;
    assign o_out_word.last          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= 16'd410;
            r_deriv_gain <= 16'd819;
            r_min_rate   <= 15'd410;
            r_max_rate   <= 15'd4915;
            r_stop_tol   <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                CFG_MIN_RATE:   r_min_rate   <= i_cfg_data[14:0];
                CFG_MAX_RATE:   r_max_rate   <= i_cfg_data[14:0];
                CFG_STOP_TOL:   r_stop_tol   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_fold  <= '0;
            r_turning       <= 1'b0;
            r_goal          <= '0;
            r_prev_err      <= '0;
            r_break_pending <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_FOLD_FIX: begin
                    r_heading_fold <= r_in_heading[15] ? $signed(rem_neg) : $signed(rem_fix);
                end
                OP_BREAK_SET: begin
                    r_break_pending <= r_in_break;
                end
                OP_START: begin
                    r_goal     <= goal_sat[9] ? goal_wrap[8:0] : goal_sat[8:0];
                    r_prev_err <= '0;
                end
                OP_ARM: begin
                    r_turning <= 1'b1;
                end
                OP_CLAMP: begin
                    r_prev_err <= r_err;
                end
                OP_BREAK_STOP: begin
                    r_break_pending <= 1'b0;
                    r_turning       <= 1'b0;
                end
                OP_FINISH: begin
                    r_turning <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_heading <= i_heading_degree;
            r_in_goal    <= i_goal_degree;
            r_in_break   <= i_break_request;
        end
        case (i_cmd.op)
            OP_FOLD_MUL: begin
                r_habs <= habs;
                r_prod <= prod;
            end
            OP_FOLD_SUB: begin
                r_rem <= fold_diff[9:0];
            end
            OP_START: begin
                r_err <= err_start;
            end
            OP_ERR: begin
                r_err <= err_tick;
            end
            OP_MUL_P: begin
                r_prod <= prod;
            end
            OP_MUL_D: begin
                r_acc  <= r_prod[MUL_A_W-1:0];
                r_prod <= prod;
            end
            OP_SUM: begin
                r_acc <= r_acc + r_prod[MUL_A_W-1:0];
            end
            OP_ABS: begin
                r_neg <= r_acc[MUL_A_W-1];
                r_abs <= r_acc[MUL_A_W-1] ? acc_neg[MUL_A_W-2:0] : r_acc[MUL_A_W-2:0];
            end
            OP_MUL_R: begin
                r_prod <= prod;
            end
            OP_ROUND: begin
                r_mag <= rnd_sum[PROD_W-1:RATE_SHIFT];
            end
            OP_CLAMP: begin
                r_rate <= neg2 ? -rate_mag : rate_mag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (i_cmd.res)
                RES_RATE: begin
                    r_out_rate   <= r_rate;
                    r_out_status <= STAT_TURNING;
                    r_out_err    <= r_err;
                    r_out_last   <= !tol_hit;
                end
                RES_DONE: begin
                    r_out_rate   <= '0;
                    r_out_status <= STAT_DONE;
                    r_out_err    <= r_err;
                    r_out_last   <= 1'b1;
                end
                RES_BREAK: begin
                    r_out_rate   <= '0;
                    r_out_status <= STAT_BROKEN;
                    r_out_err    <= r_prev_err;
                    r_out_last   <= 1'b1;
                end
                default: begin
                    r_out_rate   <= '0;
                    r_out_status <= STAT_DONE;
                    r_out_err    <= r_err;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/heading_turn_pd_controller_top.sv -----
// top level of the heading turn pd controller
//
// words enter on i_in_word (valid/ready): kind 0 stores a heading, kind 1 starts
// a turn, kind 2 sets or clears the break request, kind 3 is a control tick.
// results leave on o_out_word (valid/ready), the final one of a word marked last.
// configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data,
// one register per cycle; the user is to write them only while the block is
// idle, and the block itself does not enforce it. one word is worked at a time,
// paced by the shared 30x20 multiplier sequence; a tick word gives its rate
// result, followed by a done result when the error is within the stop tolerance.
// a tick computes error, proportional and derivative products, the radian
// scale product, rounding and clamp, one step per cycle.
// the result sits in an output register, so the next word is taken while
// it waits; a stalled receiver holds the block only when a further result
// has to be loaded.
// synchronous reset loads the register defaults, clears heading, goal,
// error and flags, and drops both valid and ready for the reset cycle.
`default_nettype none

module heading_turn_pd_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    htpd_in_if.sink                             i_in_word,
    htpd_out_if.source                          o_out_word,
    input  logic                                i_cfg_we,
    input  logic [htpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [htpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import htpd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    htpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_word (i_in_word),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    htpd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_heading_degree (i_in_word.heading_degree),
        .i_goal_degree    (i_in_word.goal_degree),
        .i_break_request  (i_in_word.break_request),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_word       (o_out_word)
    );

endmodule

`default_nettype wire

// ----- hdl/htpd_checker.sv -----
// port level checker of the heading turn pd controller and its bind
`default_nettype none
`include "heading_turn_pd_controller_top_macros.svh"

module htpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_turn_rate,
    input logic [1:0]         i_status,
    input logic signed [11:0] i_heading_error,
    input logic               i_last
);
    import htpd_pkg::*;

    `HTPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_turn_rate) && $stable(i_status) && $stable(i_heading_error) && $stable(i_last))
    `HTPD_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, i_out_valid, i_status == STAT_TURNING || i_status == STAT_DONE || i_status == STAT_BROKEN)
    `HTPD_ASSERT_IMPL(a_end_zero_rate, i_clk, i_rst_n, i_out_valid && i_status != STAT_TURNING, i_turn_rate == 16'sd0 && i_last)
    `HTPD_ASSERT_IMPL(a_more_is_turning, i_clk, i_rst_n, i_out_valid && !i_last, i_status == STAT_TURNING)
    `HTPD_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last, !i_out_valid || i_status == STAT_DONE)

endmodule

bind heading_turn_pd_controller_top htpd_checker u_htpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_word.valid),
    .i_out_ready     (o_out_word.ready),
    .i_turn_rate     (o_out_word.turn_rate),
    .i_status        (o_out_word.status),
    .i_heading_error (o_out_word.heading_error),
    .i_last          (o_out_word.last)
);

`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench of the heading turn pd controller: directed script, then random turns
module tb;
    import htpd_pkg::*;

    localparam int LIMIT_CYCLES    = 600000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WORDS_PER_PHASE = 100;
    localparam int FULL_TURN_DEG   = 360;
    localparam int SCRIPT_ROWS     = 25;

    typedef struct {
        logic signed [15:0] rate;
        logic [1:0]         status;
        logic signed [11:0] err;
        logic               last;
    } turn_result_t;

    typedef struct {
        logic [1:0] kind;
        int         heading;
        int         goal;
        logic       brk;
        logic       typed;
        int         rate;
        logic [1:0] status;
        int         err;
        logic       last;
    } script_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    htpd_in_if  in_word ();
    htpd_out_if out_word ();

    heading_turn_pd_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (in_word),
        .o_out_word  (out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    int pred_heading, pred_goal, pred_prev_err;
    bit pred_turning, pred_break;
    int pred_kp, pred_kd, pred_min, pred_max, pred_tol;

    turn_result_t turn_results_due[$];
    bit typed_row, send_calm, take_calm;
    int failures, words_sent, useful_words, results_seen, done_seen, broken_seen;
    int settings_run, cycles;

    function automatic int fold_deg(int h);
        int a;
        a = (h < 0) ? -h : h;
        a = a % FULL_TURN_DEG;
        return (h < 0) ? -a : a;
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void flag_failure(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    function automatic void queue_result(int rate, logic [1:0] status, int err, logic last);
        turn_result_t r;
        r.rate   = rate[15:0];
        r.status = status;
        r.err    = err[11:0];
        r.last   = last;
        if (!typed_row) turn_results_due.push_back(r);
    endfunction

    function automatic void predict_word(logic [1:0] kind, logic signed [15:0] hd,
                                         logic signed [9:0] gd, logic brk);
        int g, e;
        longint deg, p, mag, r, s;
        case (kind)
            KIND_HEADING: begin
                pred_heading = hd;
                useful_words++;
            end
            KIND_BREAK: begin
                pred_break = brk;
                useful_words++;
            end
            KIND_START: if (!pred_turning) begin
                useful_words++;
                g = gd;
                if (g > int'(GOAL_MAX)) g = GOAL_MAX;
                if (g < int'(GOAL_MIN)) g = GOAL_MIN;
                e = g - fold_deg(pred_heading);
                pred_goal = (g < 0) ? g + FULL_TURN_DEG : g;
                pred_prev_err = 0;
                if (abs_int(e) <= pred_tol) queue_result(0, STAT_DONE, e, 1'b1);
                else pred_turning = 1'b1;
            end
            KIND_TICK: if (pred_turning) begin
                useful_words++;
                if (pred_break) begin
                    pred_break = 1'b0;
                    pred_turning = 1'b0;
                    queue_result(0, STAT_BROKEN, pred_prev_err, 1'b1);
                end else begin
                    e = pred_goal - fold_deg(pred_heading);
                    deg = longint'(pred_kp) * e + longint'(pred_kd) * (pred_prev_err - e);
                    p = deg * longint'(DEG2RAD);
                    mag = (p < 0) ? -p : p;
                    mag = (mag + (longint'(1) << (RATE_SHIFT - 1))) >>> RATE_SHIFT;
                    r = (p < 0) ? -mag : mag;
                    s = (e < 0) ? -1 : 1;
                    // clamp to the band, min applied last so it wins over max
                    if (mag > pred_max) begin
                        r = s * pred_max;
                        mag = pred_max;
                    end
                    if (mag < pred_min) r = s * pred_min;
                    if (r > 32767) r = 32767;
                    if (r < -32768) r = -32768;
                    pred_prev_err = e;
                    if (abs_int(e) <= pred_tol) begin
                        queue_result(int'(r), STAT_TURNING, e, 1'b0);
                        queue_result(0, STAT_DONE, e, 1'b1);
                        pred_turning = 1'b0;
                    end else begin
                        queue_result(int'(r), STAT_TURNING, e, 1'b1);
                    end
                end
            end
        endcase
    endfunction

    function automatic logic signed [15:0] random_heading();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 1438)) - 719);
    endfunction

    task automatic send_word(int kind, int hd, int gd, int brk);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_word.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_word.valid          <= 1'b1;
        in_word.kind           <= kind[1:0];
        in_word.heading_degree <= hd[15:0];
        in_word.goal_degree    <= gd[9:0];
        in_word.break_request  <= brk[0];
        do @(posedge i_clk); while (!in_word.ready);
        words_sent++;
        predict_word(kind[1:0], hd[15:0], gd[9:0], brk[0]);
    endtask

    task automatic settle();
        in_word.valid <= 1'b0;
        while (turn_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(int kp, int kd, int mn, int mx, int tol);
        logic [CFG_IDX_W-1:0] idx [5];
        int                   val [5];
        idx = '{CFG_PROP_GAIN, CFG_DERIV_GAIN, CFG_MIN_RATE, CFG_MAX_RATE, CFG_STOP_TOL};
        val = '{kp, kd, mn, mx, tol};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k][CFG_DATA_W-1:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pred_kp  = kp;
        pred_kd  = kd;
        pred_min = mn;
        pred_max = mx;
        pred_tol = tol;
        settings_run++;
    endtask

    task automatic run_turn();
        int h;
        if ($urandom_range(0, 1) == 1)
            send_word(KIND_HEADING, random_heading(), $urandom, $urandom);
        if ($urandom_range(0, 5) == 0) send_word(KIND_START, $urandom, $urandom, $urandom);
        else send_word(KIND_START, $urandom, int'($urandom_range(0, 718)) - 359, $urandom);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    // heading close to the goal, sometimes a full turn or two away
                    h = pred_goal + int'($urandom_range(0, 8)) - 4
                        + FULL_TURN_DEG * int'($urandom_range(0, 2));
                    send_word(KIND_HEADING, h, $urandom, $urandom);
                end
                2: send_word(KIND_HEADING, random_heading(), $urandom, $urandom);
                3: if ($urandom_range(0, 2) == 0)
                    send_word(KIND_BREAK, $urandom, $urandom, $urandom_range(0, 1));
                default: ;
            endcase
            send_word(KIND_TICK, $urandom, $urandom, $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int           stall;
        turn_result_t want;
        out_word.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = take_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_word.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_word.ready <= 1'b1;
            do @(posedge i_clk); while (!out_word.valid);
            results_seen++;
            if (out_word.status == STAT_DONE) done_seen++;
            if (out_word.status == STAT_BROKEN) broken_seen++;
            if (turn_results_due.size() == 0) begin
                flag_failure($sformatf("unexpected word: rate %0d status %0d error %0d last %0d",
                    out_word.turn_rate, out_word.status, out_word.heading_error, out_word.last));
            end else begin
                want = turn_results_due.pop_front();
                if (out_word.turn_rate !== want.rate || out_word.status !== want.status ||
                    out_word.heading_error !== want.err || out_word.last !== want.last)
                    flag_failure($sformatf({"mismatch (exp/act): rate %0d/%0d status %0d/%0d ",
                        "error %0d/%0d last %0d/%0d"},
                        want.rate, out_word.turn_rate, want.status, out_word.status,
                        want.err, out_word.heading_error, want.last, out_word.last));
            end
        end
    end

    initial begin : stimulus
        script_row_t script [SCRIPT_ROWS];
        int          phase_start;
        in_word.valid          <= 1'b0;
        in_word.kind           <= KIND_HEADING;
        in_word.heading_degree <= '0;
        in_word.goal_degree    <= '0;
        in_word.break_request  <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_index            <= CFG_PROP_GAIN;
        i_cfg_data             <= '0;
        i_rst_n                <= 1'b0;
        pred_kp  = 410;
        pred_kd  = 819;
        pred_min = 410;
        pred_max = 4915;
        pred_tol = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        script = '{
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0}, // idle tick
            '{KIND_START,   0,      0,    1'b0, 1'b1, 0, STAT_DONE,    0,   1'b1},
            '{KIND_HEADING, 32767,  0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_START,   0,      8,    1'b0, 1'b1, 0, STAT_DONE,    1,   1'b1},
            '{KIND_HEADING, -32768, 0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_START,   0,      -9,   1'b0, 1'b1, 0, STAT_DONE,    -1,  1'b1},
            '{KIND_START,   0,      511,  1'b1, 1'b0, 0, STAT_TURNING, 0,   1'b0}, // saturated goal
            '{KIND_START,   0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0}, // while turning
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_BREAK,   0,      0,    1'b1, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_TICK,    0,      0,    1'b0, 1'b1, 0, STAT_BROKEN,  367, 1'b1},
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_HEADING, 100,    0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_BREAK,   0,      0,    1'b1, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_START,   0,      100,  1'b0, 1'b1, 0, STAT_DONE,    0,   1'b1}, // break kept
            '{KIND_START,   0,      -512, 1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_TICK,    0,      0,    1'b0, 1'b1, 0, STAT_BROKEN,  0,   1'b1},
            '{KIND_HEADING, -360,   0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_START,   0,      3,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0}, // below min
            '{KIND_HEADING, 362,    0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_TICK,    0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0}, // rate then done
            '{KIND_BREAK,   0,      0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0},
            '{KIND_HEADING, 255,    0,    1'b0, 1'b0, 0, STAT_TURNING, 0,   1'b0}
        };
        foreach (script[k]) begin
            typed_row = script[k].typed;
            send_word(script[k].kind, script[k].heading, script[k].goal, script[k].brk);
            typed_row = 1'b0;
            if (script[k].typed)
                queue_result(script[k].rate, script[k].status, script[k].err, script[k].last);
        end

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: load_settings(410, 819, 410, 4915, 1);
                1: load_settings(65535, 65535, 32767, 32767, 359);
                2: load_settings(0, 0, 0, 0, 0);
                3: load_settings($urandom_range(0, 4000), $urandom_range(0, 4000),
                                 $urandom_range(2000, 32767), $urandom_range(0, 1999),
                                 $urandom_range(0, 10));
                4: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 32767), $urandom_range(0, 32767),
                                 $urandom_range(0, 359));
                default: load_settings($urandom_range(0, 2000), $urandom_range(0, 2000),
                                       $urandom_range(0, 800), $urandom_range(800, 32767),
                                       $urandom_range(0, 5));
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE) begin
                send_calm = ($urandom_range(0, 3) == 0);
                take_calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4))
                        send_word($urandom_range(0, 3), $urandom, $urandom, $urandom);
                end else begin
                    run_turn();
                end
            end
        end

        settle();
        $display("covered %0d words (%0d acted on) under %0d register settings",
                 words_sent, useful_words, settings_run);
        $display("checked %0d result words: %0d turns done, %0d broken off, %0d failures",
                 results_seen, done_seen, broken_seen, failures);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
